>>> rtl/ilp_pkg.sv
// Shared types, constants and lookup functions for the interval literal parser.
// Depends on nothing; every other file in rtl imports it.
package ilp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CHAR_W      = 8;
  localparam int QUAL_W      = 4;
  localparam int ACC_W       = 63;
  localparam int MS_W        = 10;
  localparam int TOTAL_W     = 64;
  localparam int UNIT_W      = 27;
  localparam int STATUS_W    = 2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  localparam logic [QUAL_W-1:0] QUAL_YEAR   = 4'd1;
  localparam logic [QUAL_W-1:0] QUAL_MONTH  = 4'd3;
  localparam logic [QUAL_W-1:0] QUAL_SECOND = 4'd13;

  localparam logic [ACC_W-1:0] ACC_MAX       = {ACC_W{1'b1}};
  localparam logic [MS_W-1:0]  SEC_REM_LIMIT = 10'd807;

  typedef enum logic [2:0] {
    F_YEAR  = 3'd0,
    F_MONTH = 3'd1,
    F_DAY   = 3'd2,
    F_HOUR  = 3'd3,
    F_MIN   = 3'd4,
    F_SEC   = 3'd5
  } field_t;

  typedef enum logic [2:0] {
    PH_SIGN   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_FRAC   = 3'b100
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SEP   = 2'd2,
    ST_TRAIL = 2'd3
  } status_t;

  // One closed field, or the end of a literal, handed from the parser to the adder.
  typedef struct packed {
    logic              is_end;
    logic              add_en;
    field_t            field;
    logic              neg;
    logic [ACC_W-1:0]  acc;
    logic [MS_W-1:0]   ms;
    status_t           status;
    logic              kind;
  } entry_t;

  function automatic logic [QUAL_W-1:0] qual_clamp(input logic [QUAL_W-1:0] q);
    logic [QUAL_W-1:0] r;
    r = q;
    if (q < QUAL_YEAR) r = QUAL_YEAR;
    if (q > QUAL_SECOND) r = QUAL_SECOND;
    return r;
  endfunction

  function automatic field_t start_field(input logic [QUAL_W-1:0] q);
    field_t f;
    case (q)
      4'd1, 4'd2:               f = F_YEAR;
      4'd3:                     f = F_MONTH;
      4'd4, 4'd5, 4'd6, 4'd7:   f = F_DAY;
      4'd8, 4'd9, 4'd10:        f = F_HOUR;
      4'd11, 4'd12:             f = F_MIN;
      default:                  f = F_SEC;
    endcase
    return f;
  endfunction

  function automatic field_t last_field(input logic [QUAL_W-1:0] q);
    field_t f;
    case (q)
      4'd1:                     f = F_YEAR;
      4'd2, 4'd3:               f = F_MONTH;
      4'd4:                     f = F_DAY;
      4'd5, 4'd8:               f = F_HOUR;
      4'd6, 4'd9, 4'd11:        f = F_MIN;
      default:                  f = F_SEC;
    endcase
    return f;
  endfunction

  // Largest value the leading field may hold without overflowing the total.
  function automatic logic [ACC_W-1:0] first_limit(input field_t f);
    logic [ACC_W-1:0] lim;
    case (f)
      F_YEAR:  lim = 63'd178956970;
      F_MONTH: lim = 63'd2147483647;
      F_DAY:   lim = 63'd106751991167;
      F_HOUR:  lim = 63'd2562047788015;
      F_MIN:   lim = 63'd153722867280912;
      default: lim = 63'd9223372036854775;
    endcase
    return lim;
  endfunction

  // Exclusive bound for a field that follows another one.
  function automatic logic [ACC_W-1:0] later_limit(input field_t f);
    logic [ACC_W-1:0] lim;
    case (f)
      F_MONTH: lim = 63'd12;
      F_HOUR:  lim = 63'd24;
      F_MIN:   lim = 63'd60;
      F_SEC:   lim = 63'd60;
      default: lim = '0;
    endcase
    return lim;
  endfunction

  // Seconds are scaled by 1000 here and their fraction is added afterward.
  function automatic logic [UNIT_W-1:0] unit_of(input field_t f);
    logic [UNIT_W-1:0] u;
    case (f)
      F_YEAR:  u = 27'd12;
      F_MONTH: u = 27'd1;
      F_DAY:   u = 27'd86400000;
      F_HOUR:  u = 27'd3600000;
      F_MIN:   u = 27'd60000;
      default: u = 27'd1000;
    endcase
    return u;
  endfunction

  function automatic logic [CHAR_W-1:0] separator(input field_t f);
    logic [CHAR_W-1:0] s;
    case (f)
      F_YEAR, F_MONTH: s = CH_MINUS;
      F_DAY:           s = CH_SPACE;
      default:         s = CH_COLON;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/interval_literal_parser.sv
// SQL interval literal parser, top level: parser front end, entry queue, adder back end.
// Depends on ilp_pkg, ilp_front, ilp_queue and ilp_back.
//
// One character beat is taken every cycle while the internal queue has room; after
// its NUL beat, the result of a literal passes through the queue, the two multiply
// and accumulate stages and the result register before it reaches the result port.
// Each accepted character yields at most one queue entry, so a stalled result port
// backs up into char_ready only after QDEPTH closed fields or ends are waiting.
// Writing qualifier_code restarts parsing and is meant for an idle block.
module interval_literal_parser import ilp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 qualifier_we,
  input  logic [QUAL_W-1:0]    qualifier_code,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  logic [CHAR_W-1:0]    char_code,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [TOTAL_W-1:0]   total_value,
  output logic                 interval_kind,
  output logic [STATUS_W-1:0]  status
);

  logic   q_full;
  logic   q_nonempty;
  logic   q_pop;
  logic   push;
  entry_t push_entry;
  entry_t q_head;

  assign char_ready = !q_full;

  ilp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (qualifier_we),
    .cfg_data  (qualifier_code),
    .accept    (char_valid && char_ready),
    .char_code (char_code),
    .push      (push),
    .entry     (push_entry)
  );

  ilp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  ilp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .clear         (qualifier_we),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .total_value   (total_value),
    .interval_kind (interval_kind),
    .status        (status)
  );

endmodule

>>> rtl/ilp_front.sv
// Character parser: tracks field, sign, digits and fraction, checks ranges and
// separators, and pushes closed fields and literal ends into the queue. Uses ilp_pkg.
module ilp_front import ilp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [QUAL_W-1:0]   cfg_data,
  input  logic                accept,
  input  logic [CHAR_W-1:0]   char_code,
  output logic                push,
  output entry_t              entry
);

  logic [QUAL_W-1:0] qual;
  field_t            field, field_next;
  phase_t            phase, phase_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic              sat, sat_next;
  logic [MS_W-1:0]   frac_ms, frac_ms_next;
  logic [1:0]        frac_cnt, frac_cnt_next;
  logic              sign, sign_next;
  status_t           err, err_next;

  logic [QUAL_W-1:0] q;
  logic              is_digit;
  logic [3:0]        digit;
  logic [MS_W-1:0]   ms_pad;
  logic [ACC_W-1:0]  lim;
  logic              bad;
  logic              is_last;
  status_t           fin_status;
  logic [ACC_W+3:0]  acc_wide;
  logic              acc_over;

  always_comb begin
    q        = qual_clamp(qual);
    is_digit = char_code inside {[CH_ZERO:CH_NINE]};
    digit    = char_code[3:0];

    case (frac_cnt)
      2'd0:    ms_pad = '0;
      2'd1:    ms_pad = MS_W'(frac_ms * 10'd100);
      2'd2:    ms_pad = MS_W'(frac_ms * 10'd10);
      default: ms_pad = frac_ms;
    endcase

    lim = first_limit(field);
    if (sat) begin
      bad = 1'b1;
    end else if (field == start_field(q)) begin
      bad = (acc > lim) || (field == F_SEC && acc == lim && ms_pad > SEC_REM_LIMIT);
    end else begin
      bad = acc >= later_limit(field);
    end

    is_last = (field == last_field(q));
    if (bad) begin
      fin_status = ST_RANGE;
    end else if (!is_last) begin
      fin_status = (char_code == separator(field)) ? ST_OK : ST_SEP;
    end else begin
      fin_status = (char_code != CH_NUL) ? ST_TRAIL : ST_OK;
    end

    // acc * 10 + digit; any bit at or above bit 63 means the run saturates.
    acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, digit};
    acc_over = |acc_wide[ACC_W+3:ACC_W];
  end

  always_comb begin
    field_next    = field;
    phase_next    = phase;
    acc_next      = acc;
    sat_next      = sat;
    frac_ms_next  = frac_ms;
    frac_cnt_next = frac_cnt;
    sign_next     = sign;
    err_next      = err;
    push          = 1'b0;

    entry.is_end = 1'b0;
    entry.add_en = 1'b0;
    entry.field  = field;
    entry.neg    = sign;
    entry.acc    = acc;
    entry.ms     = ms_pad;
    entry.status = ST_OK;
    entry.kind   = (q <= QUAL_MONTH) ? 1'b0 : 1'b1;

    if (cfg_we) begin
      field_next    = start_field(qual_clamp(cfg_data));
      phase_next    = PH_SIGN;
      acc_next      = '0;
      sat_next      = 1'b0;
      frac_ms_next  = '0;
      frac_cnt_next = '0;
      sign_next     = 1'b0;
      err_next      = ST_OK;
    end else if (accept) begin
      if (char_code == CH_NUL) begin
        push          = 1'b1;
        entry.is_end  = 1'b1;
        entry.status  = (err != ST_OK) ? err : fin_status;
        entry.add_en  = (err == ST_OK) && (fin_status == ST_OK);
        field_next    = start_field(q);
        phase_next    = PH_SIGN;
        acc_next      = '0;
        sat_next      = 1'b0;
        frac_ms_next  = '0;
        frac_cnt_next = '0;
        sign_next     = 1'b0;
        err_next      = ST_OK;
      end else if (err == ST_OK) begin
        if (phase == PH_SIGN && char_code == CH_MINUS) begin
          sign_next  = !sign;
          phase_next = PH_DIGITS;
        end else if (phase != PH_FRAC && is_digit) begin
          phase_next = PH_DIGITS;
          if (sat || acc_over) begin
            sat_next = 1'b1;
            acc_next = ACC_MAX;
          end else begin
            acc_next = acc_wide[ACC_W-1:0];
          end
        end else if (phase != PH_FRAC && char_code == CH_DOT && field == F_SEC) begin
          phase_next = PH_FRAC;
        end else if (phase == PH_FRAC && is_digit) begin
          if (frac_cnt != 2'd3) begin
            frac_ms_next  = MS_W'(frac_ms * 10'd10) + {6'b0, digit};
            frac_cnt_next = frac_cnt + 2'd1;
          end
        end else if (fin_status == ST_OK) begin
          // Separator seen: the field is closed and the next one begins.
          push          = 1'b1;
          entry.add_en  = 1'b1;
          field_next    = field_t'(field + 3'd1);
          phase_next    = PH_SIGN;
          acc_next      = '0;
          sat_next      = 1'b0;
          frac_ms_next  = '0;
          frac_cnt_next = '0;
        end else begin
          err_next = fin_status;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qual     <= QUAL_SECOND;
      field    <= F_SEC;
      phase    <= PH_SIGN;
      acc      <= '0;
      sat      <= 1'b0;
      frac_ms  <= '0;
      frac_cnt <= '0;
      sign     <= 1'b0;
      err      <= ST_OK;
    end else begin
      if (cfg_we) qual <= cfg_data;
      field    <= field_next;
      phase    <= phase_next;
      acc      <= acc_next;
      sat      <= sat_next;
      frac_ms  <= frac_ms_next;
      frac_cnt <= frac_cnt_next;
      sign     <= sign_next;
      err      <= err_next;
    end
  end

endmodule

>>> rtl/ilp_queue.sv
// Small circular queue of parser entries between the parser and the adder.
// Uses entry_t from ilp_pkg.
module ilp_queue import ilp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output logic    full,
  output logic    nonempty,
  output entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ilp_back.sv
// Adder back end: scales each closed field by its unit in two partial products,
// sums into the running total and drives the result register. Uses ilp_pkg.
module ilp_back import ilp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  q_nonempty,
  input  entry_t                q_head,
  output logic                  q_pop,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [TOTAL_W-1:0]    total_value,
  output logic                  interval_kind,
  output logic [STATUS_W-1:0]   status
);

  // Stage 1: partial products of the field value and its unit.
  logic                      s1_valid;
  entry_t                    s1;
  logic [58:0]               s1_lo;
  logic [57:0]               s1_hi;
  // Stage 2: the scaled field value.
  logic                      s2_valid;
  entry_t                    s2;
  logic [TOTAL_W-1:0]        s2_prod;

  logic [TOTAL_W-1:0]        total;
  logic [TOTAL_W-1:0]        addend;
  logic [TOTAL_W-1:0]        total_sum;
  logic [UNIT_W-1:0]         unit;
  logic [MS_W-1:0]           ms_term;
  logic                      en;

  // The pipeline only stops when a literal end reaches the full result register.
  assign en    = !(s2_valid && s2.is_end && result_valid && !result_ready);
  assign q_pop = en;
  assign unit  = unit_of(q_head.field);

  always_comb begin
    ms_term   = (s1.field == F_SEC) ? s1.ms : '0;
    addend    = s2_prod ^ {TOTAL_W{s2.neg}};
    total_sum = s2.add_en ? (total + addend + {{(TOTAL_W-1){1'b0}}, s2.neg}) : total;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1      <= q_head;
      s1_lo   <= q_head.acc[31:0] * unit;
      s1_hi   <= q_head.acc[ACC_W-1:32] * unit;
      s2      <= s1;
      s2_prod <= TOTAL_W'(s1_lo) + (TOTAL_W'(s1_hi) << 32) + TOTAL_W'(ms_term);
    end
    if (en && s2_valid && s2.is_end) begin
      total_value   <= (s2.status == ST_OK) ? total_sum : '0;
      interval_kind <= s2.kind;
      status        <= s2.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= q_nonempty;
        s2_valid <= s1_valid;
      end
      // A qualifier write drops the partial sum of an abandoned literal.
      if (clear) begin
        total <= '0;
      end else if (en && s2_valid) begin
        total <= s2.is_end ? '0 : total_sum;
      end
      if (en && s2_valid && s2.is_end) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/ilp_checker.sv
// Port-level checks for interval_literal_parser, bound to the top level below.
// Depends on ilp_pkg for the status codes.
module ilp_checker import ilp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 qualifier_we,
  input logic [QUAL_W-1:0]    qualifier_code,
  input logic                 char_valid,
  input logic                 char_ready,
  input logic [CHAR_W-1:0]    char_code,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [TOTAL_W-1:0]   total_value,
  input logic                 interval_kind,
  input logic [STATUS_W-1:0]  status
);

  // A failed literal always reports a zero total.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> total_value == '0)
    else $error("nonzero total with error status");

  // Reset empties the result register.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present after reset");

  // A result beat holds while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(total_value) && $stable(status) && $stable(interval_kind))
    else $error("result beat changed under stall");

  // A result beat never rises straight out of reset.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(rst))
    else $error("result beat straight out of reset");

endmodule

bind interval_literal_parser ilp_checker u_ilp_checker (.*);
